/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_ALWAYS(label, !(expr), msg)

`endif

/* rtl/npcr_pkg.sv */
`default_nettype none
package npcr_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int COLOR_W          = 24;
    localparam int INDEX_W          = 8;
    localparam int DIST_W           = 18;
    localparam int SQ_W             = 16;
    localparam int CFG_AW           = 3;

    localparam logic [DIST_W-1:0]  DIST_INIT         = '1;
    localparam logic [INDEX_W-1:0] TRANSPARENT_PIXEL = 8'd254;
    localparam logic [INDEX_W-1:0] BACKGROUND_PIXEL  = 8'd255;
    localparam logic [8:0]         SRC_COUNT_RESET   = 9'd256;

    // register index decoded from paddr above the byte offset
    localparam logic [CFG_AW-3:0]  REG_SRC_COUNT     = '0;

    localparam logic KIND_NEAREST = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PAL_WRITE = 2'd0,
        ACT_QUERY     = 2'd1,
        ACT_SRC_WRITE = 2'd2,
        ACT_REMAP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT,
        ST_PIXEL
    } state_t;

    typedef struct packed {
        action_t              action;
        logic [INDEX_W-1:0]   entry_index;
        logic [COLOR_W-1:0]   color_rgb;
        logic [INDEX_W-1:0]   pixel_value;
    } cmd_t;

    typedef struct packed {
        logic                 answer_kind;
        logic [INDEX_W-1:0]   nearest_index;
        logic [COLOR_W-1:0]   nearest_color;
        logic [INDEX_W-1:0]   mapped_pixel;
    } result_t;

    // palette entry handed from the ring head to the distance unit
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [INDEX_W-1:0]   index;
        logic [COLOR_W-1:0]   color;
    } feed_t;

    typedef struct packed {
        logic                 done;
        logic [INDEX_W-1:0]   index;
        logic [COLOR_W-1:0]   color;
    } best_t;

endpackage
`default_nettype wire

/* rtl/npcr_cell.sv */
`default_nettype none
module npcr_cell
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire logic                          wr_en,
    input  wire logic [npcr_pkg::COLOR_W-1:0]  wdata,
    input  wire logic [npcr_pkg::COLOR_W-1:0]  neighbor,
    output logic      [npcr_pkg::COLOR_W-1:0]  q
);
    import npcr_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    always_comb
    begin
        color_next = color_reg;
        if (wr_en)
        begin
            color_next = wdata;
        end
        else if (shift)
        begin
            color_next = neighbor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    assign q = color_reg;

endmodule
`default_nettype wire

/* rtl/npcr_dist.sv */
`default_nettype none
module npcr_dist
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [npcr_pkg::COLOR_W-1:0]  query_color,
    input  wire npcr_pkg::feed_t               feed,
    output npcr_pkg::best_t                    best
);
    import npcr_pkg::*;

    logic [7:0]         dr;
    logic [7:0]         dg;
    logic [7:0]         db;
    logic [SQ_W-1:0]    sq_r_next;
    logic [SQ_W-1:0]    sq_g_next;
    logic [SQ_W-1:0]    sq_b_next;

    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;
    logic               a_valid_reg;
    logic               a_first_reg;
    logic               a_last_reg;
    logic [INDEX_W-1:0] a_index_reg;
    logic [COLOR_W-1:0] a_color_reg;

    logic [DIST_W-1:0]  sum;
    logic               take;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [INDEX_W-1:0] best_index_reg;
    logic [COLOR_W-1:0] best_color_reg;
    logic               done_reg;

    // stage A: per-channel absolute difference and square
    always_comb
    begin
        dr = (feed.color[7:0] > query_color[7:0]) ? feed.color[7:0] - query_color[7:0]
                                                 : query_color[7:0] - feed.color[7:0];
        dg = (feed.color[15:8] > query_color[15:8]) ? feed.color[15:8] - query_color[15:8]
                                                   : query_color[15:8] - feed.color[15:8];
        db = (feed.color[23:16] > query_color[23:16]) ? feed.color[23:16] - query_color[23:16]
                                                     : query_color[23:16] - feed.color[23:16];
        sq_r_next = SQ_W'(dr) * SQ_W'(dr);
        sq_g_next = SQ_W'(dg) * SQ_W'(dg);
        sq_b_next = SQ_W'(db) * SQ_W'(db);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= feed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg    <= sq_r_next;
        sq_g_reg    <= sq_g_next;
        sq_b_reg    <= sq_b_next;
        a_first_reg <= feed.first;
        a_last_reg  <= feed.last;
        a_index_reg <= feed.index;
        a_color_reg <= feed.color;
    end

    // stage B: sum and compare; strict less keeps the lowest index on a tie
    assign sum  = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take = a_first_reg || (sum < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg  <= DIST_INIT;
            best_index_reg <= '0;
            best_color_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= a_valid_reg && a_last_reg;
            if (a_valid_reg && take)
            begin
                best_dist_reg  <= sum;
                best_index_reg <= a_index_reg;
                best_color_reg <= a_color_reg;
            end
        end
    end

    assign best.done  = done_reg;
    assign best.index = best_index_reg;
    assign best.color = best_color_reg;

endmodule
`default_nettype wire

/* rtl/nearest_palette_color_remap.sv */
`default_nettype none
// Nearest palette color search and pixel remapper.
// Command channel: a word on cmd is taken at a clock edge with start high and
// busy low. Actions: palette write, nearest query, source entry write, pixel
// remap. Results leave on result, flagged by result_valid for one cycle; the
// receiver always takes them.
// The palette sits in a ring of PALETTE_SIZE cells. A search rotates the ring
// once past a single distance unit (abs diff, square, then sum and compare),
// so a query or source write keeps busy high until the search is done, and
// a query answer is strobed in the first cycle with busy low again.
// A palette write leaves busy low and returns nothing. A pixel remap reads
// the remap memory into a register, then answers from ST_PIXEL via result_reg.
// The APB port holds source_color_count at byte address 0.
// Reset clears the palette to zero and sets source_color_count to 256; the
// remap memory holds nothing useful until written.
// The receiver cannot stall, so no result is ever held back.
module nearest_palette_color_remap
#(
    parameter int PALETTE_SIZE = npcr_pkg::PALETTE_SIZE_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire npcr_pkg::cmd_t               cmd,
    output logic                              result_valid,
    output npcr_pkg::result_t                 result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [npcr_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import npcr_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_SIZE - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [8:0]          src_count_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             result_next;

    action_t             qaction_reg;
    logic [COLOR_W-1:0]  qcolor_reg;
    logic [INDEX_W-1:0]  qentry_reg;
    logic [INDEX_W-1:0]  pixel_reg;
    logic                pass_reg;
    logic                pass_now;

    logic [INDEX_W-1:0]  remap_mem [256];
    logic [INDEX_W-1:0]  mem_rdata_reg;
    logic                mem_we;

    logic                accept;
    logic                shift;
    logic                cfg_write;
    logic [COLOR_W-1:0]  cell_q [PALETTE_SIZE];
    feed_t               feed;
    best_t               best;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[CFG_AW-1:2] == REG_SRC_COUNT) ? {23'd0, src_count_reg} : 32'd0;

    // palette ring: cell i hands its entry to cell i-1, cell 0 feeds the unit
    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_cell
        localparam int NEIGHBOR = (i + 1) % PALETTE_SIZE;
        npcr_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .wr_en    (accept && (cmd.action == ACT_PAL_WRITE) &&
                       (cmd.entry_index == INDEX_W'(i))),
            .wdata    (cmd.color_rgb),
            .neighbor (cell_q[NEIGHBOR]),
            .q        (cell_q[i])
        );
    end

    assign feed.valid = (state_reg == ST_SEARCH);
    assign feed.first = (cnt_reg == '0);
    assign feed.last  = (cnt_reg == CNT_LAST);
    assign feed.index = INDEX_W'(cnt_reg);
    assign feed.color = cell_q[0];

    npcr_dist u_dist
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_color (qcolor_reg),
        .feed        (feed),
        .best        (best)
    );

    // pixels at or above the count, and the two reserved indices, pass through
    assign pass_now = (!src_count_reg[8] && (cmd.pixel_value >= src_count_reg[7:0])) ||
                      (cmd.pixel_value == TRANSPARENT_PIXEL) ||
                      (cmd.pixel_value == BACKGROUND_PIXEL);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        shift             = 1'b0;
        mem_we            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_QUERY, ACT_SRC_WRITE:
                        begin
                            state_next = ST_SEARCH;
                            cnt_next   = '0;
                        end
                        ACT_REMAP:
                        begin
                            state_next = ST_PIXEL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                shift = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (best.done)
                begin
                    state_next = ST_IDLE;
                    if (qaction_reg == ACT_QUERY)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.answer_kind   = KIND_NEAREST;
                        result_next.nearest_index = best.index;
                        result_next.nearest_color = best.color;
                        result_next.mapped_pixel  = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_PIXEL:
            begin
                state_next                = ST_IDLE;
                result_valid_next         = 1'b1;
                result_next.answer_kind   = KIND_PIXEL;
                result_next.nearest_index = '0;
                result_next.nearest_color = '0;
                result_next.mapped_pixel  = pass_reg ? pixel_reg : mem_rdata_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            src_count_reg    <= SRC_COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write && (paddr[CFG_AW-1:2] == REG_SRC_COUNT))
            begin
                src_count_reg <= pwdata[8:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            qaction_reg <= cmd.action;
            qcolor_reg  <= cmd.color_rgb;
            qentry_reg  <= cmd.entry_index;
            pixel_reg   <= cmd.pixel_value;
            pass_reg    <= pass_now;
        end
    end

    // remap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            remap_mem[qentry_reg] <= best.index;
        end
        if (accept)
        begin
            mem_rdata_reg <= remap_mem[cmd.pixel_value];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_ALWAYS(a_strobe_single, result_valid |=> !result_valid, "result strobe held two cycles")
    `ASSERT_NEVER(a_strobe_while_busy, result_valid && busy, "result strobe while busy")
    `ASSERT_ALWAYS(a_done_in_wait, best.done |-> (state_reg == ST_WAIT), "search done outside wait")
    `ASSERT_ALWAYS(a_search_busy,
                   (accept && (cmd.action == ACT_QUERY)) |=> (state_reg == ST_SEARCH),
                   "query did not start a search")

endmodule
`default_nettype wire

/* tb/sv/nearest_palette_color_remap_test.sv */
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_remap_test;
    import npcr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PAL_N       = PALETTE_SIZE_DEF;
    localparam int PHASE_ITEMS = 98;
    localparam logic [CFG_AW-1:0] ADDR_SRC_COUNT = {REG_SRC_COUNT, 2'b00};

    // Predicts the answers of the remapper and holds those still owed.
    class nearest_color_board;
        logic [COLOR_W-1:0] palette [PAL_N];
        logic [INDEX_W-1:0] remap_tbl [256];
        bit                 remap_set [256];
        int unsigned        color_count;
        result_t            owed [$];
        int                 fail_count;

        function new();
            foreach (palette[i]) palette[i] = '0;
            foreach (remap_tbl[i]) remap_tbl[i] = '0;
            foreach (remap_set[i]) remap_set[i] = 1'b0;
            color_count = 256;
            fail_count = 0;
        endfunction

        function int unsigned chan_sq(logic [7:0] a, logic [7:0] b);
            int diff;
            diff = int'(a) - int'(b);
            return diff * diff;
        endfunction

        // lowest index wins a tie, since only a strictly smaller distance replaces
        function logic [INDEX_W-1:0] nearest_entry(logic [COLOR_W-1:0] color);
            int unsigned best_d;
            int unsigned d;
            logic [INDEX_W-1:0] best_k;
            best_d = DIST_INIT;
            best_k = '0;
            for (int i = 0; i < PAL_N; i++)
            begin
                d = chan_sq(palette[i][7:0], color[7:0])
                  + chan_sq(palette[i][15:8], color[15:8])
                  + chan_sq(palette[i][23:16], color[23:16]);
                if (d < best_d)
                begin
                    best_d = d;
                    best_k = INDEX_W'(i);
                end
            end
            return best_k;
        endfunction

        function int unsigned live_count();
            return (color_count > 256) ? 256 : color_count;
        endfunction

        function bit table_needed(logic [INDEX_W-1:0] px);
            return (px < live_count()) && (px != TRANSPARENT_PIXEL) && (px != BACKGROUND_PIXEL);
        endfunction

        function void note_cmd(cmd_t c);
            result_t r;
            logic [INDEX_W-1:0] k;
            r = '0;
            case (c.action)
                ACT_PAL_WRITE:
                begin
                    if (c.entry_index < PAL_N)
                        palette[c.entry_index] = c.color_rgb;
                end
                ACT_QUERY:
                begin
                    k = nearest_entry(c.color_rgb);
                    r.answer_kind = KIND_NEAREST;
                    r.nearest_index = k;
                    r.nearest_color = palette[k];
                    owed.push_back(r);
                end
                ACT_SRC_WRITE:
                begin
                    remap_tbl[c.entry_index] = nearest_entry(c.color_rgb);
                    remap_set[c.entry_index] = 1'b1;
                end
                default:
                begin
                    r.answer_kind = KIND_PIXEL;
                    r.mapped_pixel = table_needed(c.pixel_value) ? remap_tbl[c.pixel_value]
                                                                 : c.pixel_value;
                    owed.push_back(r);
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                $error("result word with nothing owed: %h", got);
                fail_count++;
                return;
            end
            want = owed.pop_front();
            if (got.answer_kind !== want.answer_kind)
            begin
                $error("answer_kind expected %0d got %0d", want.answer_kind, got.answer_kind);
                fail_count++;
            end
            if (got.nearest_index !== want.nearest_index)
            begin
                $error("nearest_index expected %0d got %0d",
                       want.nearest_index, got.nearest_index);
                fail_count++;
            end
            if (got.nearest_color !== want.nearest_color)
            begin
                $error("nearest_color expected %h got %h", want.nearest_color, got.nearest_color);
                fail_count++;
            end
            if (got.mapped_pixel !== want.mapped_pixel)
            begin
                $error("mapped_pixel expected %0d got %0d", want.mapped_pixel, got.mapped_pixel);
                fail_count++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    cmd_t              cmd = '0;
    logic              result_valid;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    nearest_color_board sb;
    int unsigned        cycle_count = 0;

    nearest_palette_color_remap uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_cmd(cmd);
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic cmd_t make_cmd(action_t act, logic [7:0] entry, logic [23:0] color,
                                      logic [7:0] px);
        cmd_t c;
        c.action = act;
        c.entry_index = entry;
        c.color_rgb = color;
        c.pixel_value = px;
        return c;
    endfunction

    // first pixel from a random point that the remap table can answer
    function automatic logic [7:0] answerable_pixel();
        logic [7:0] p;
        logic [7:0] origin;
        origin = 8'($urandom_range(0, 255));
        for (int i = 0; i < 256; i++)
        begin
            p = origin + 8'(i);
            if (!sb.table_needed(p) || sb.remap_set[p])
                return p;
        end
        return BACKGROUND_PIXEL;
    endfunction

    function automatic cmd_t random_cmd(bit fill_palette);
        cmd_t c;
        int unsigned roll;
        c.entry_index = 8'($urandom_range(0, 255));
        c.color_rgb = 24'($urandom_range(0, 24'hFFFFFF));
        c.pixel_value = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (fill_palette || roll < 20)
            c.action = ACT_PAL_WRITE;
        else if (roll < 40)
            c.action = ACT_QUERY;
        else if (roll < 60)
            c.action = ACT_SRC_WRITE;
        else
            c.action = ACT_REMAP;
        // exact or near palette colors give ties and close calls
        if (c.action != ACT_REMAP && $urandom_range(0, 2) == 0)
            c.color_rgb = sb.palette[$urandom_range(0, PAL_N - 1)]
                        ^ ($urandom_range(0, 1) ? 24'h0 : (24'($urandom) & 24'h030303));
        if (c.action == ACT_REMAP && $urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: c.pixel_value = 8'(sb.live_count() - 1);
                1: c.pixel_value = 8'(sb.live_count());
                2: c.pixel_value = TRANSPARENT_PIXEL;
                default: c.pixel_value = BACKGROUND_PIXEL;
            endcase
        end
        if (c.action == ACT_REMAP && sb.table_needed(c.pixel_value)
            && !sb.remap_set[c.pixel_value])
            c.pixel_value = answerable_pixel();
        return c;
    endfunction

    task automatic issue(cmd_t c, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (busy || sb.owed.size() != 0);
    endtask

    task automatic apb_access(bit is_write, logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= ADDR_SRC_COUNT;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_count_reg();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(sb.color_count))
        begin
            $error("source_color_count expected %0d got %0d", sb.color_count, rd);
            sb.fail_count++;
        end
    endtask

    // searches and source writes keep working after the last answer; let them finish
    task automatic set_count(int unsigned value);
        logic [31:0] rd;
        drain();
        repeat (PAL_N + 8) @(posedge clk);
        apb_access(1'b1, 32'(value), rd);
        sb.color_count = value & 9'h1FF;
        check_count_reg();
    endtask

    initial
    begin
        int unsigned counts [8];
        bit calm;
        sb = new();
        counts = '{256, 0, 511, 1, 255, 254, 0, 200};
        counts[6] = $urandom_range(0, 256);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_count_reg();

        // empty palette: everything ties at entry 0, even the farthest color
        issue(make_cmd(ACT_QUERY, 8'd0, 24'h000000, 8'd0), 1'b1);
        issue(make_cmd(ACT_QUERY, 8'd255, 24'hFFFFFF, 8'd255), 1'b1);
        issue(make_cmd(ACT_PAL_WRITE, 8'd0, 24'hFFFFFF, 8'd0), 1'b1);
        issue(make_cmd(ACT_PAL_WRITE, 8'd1, 24'h0000FF, 8'd0), 1'b0);
        issue(make_cmd(ACT_PAL_WRITE, 8'd2, 24'h00FF00, 8'd0), 1'b0);
        issue(make_cmd(ACT_PAL_WRITE, 8'd3, 24'hFF0000, 8'd0), 1'b0);
        issue(make_cmd(ACT_PAL_WRITE, 8'd255, 24'h808080, 8'd0), 1'b1);
        issue(make_cmd(ACT_PAL_WRITE, 8'd5, 24'h0000FF, 8'd0), 1'b1);
        issue(make_cmd(ACT_QUERY, 8'd0, 24'h0000F0, 8'd0), 1'b1);
        issue(make_cmd(ACT_QUERY, 8'd0, 24'h000000, 8'd0), 1'b0);
        issue(make_cmd(ACT_QUERY, 8'd0, 24'hFFFFFF, 8'd0), 1'b0);
        issue(make_cmd(ACT_QUERY, 8'd0, 24'h7F8081, 8'd0), 1'b1);
        issue(make_cmd(ACT_QUERY, 8'd0, 24'h00FF00, 8'd0), 1'b0);
        issue(make_cmd(ACT_SRC_WRITE, 8'd0, 24'h0000FF, 8'd0), 1'b1);
        issue(make_cmd(ACT_SRC_WRITE, 8'd255, 24'hFFFFFF, 8'd0), 1'b0);
        issue(make_cmd(ACT_SRC_WRITE, 8'd254, 24'h00FF00, 8'd0), 1'b1);
        issue(make_cmd(ACT_SRC_WRITE, 8'd1, 24'h808081, 8'd0), 1'b0);
        issue(make_cmd(ACT_REMAP, 8'd0, 24'h0, 8'd0), 1'b0);
        issue(make_cmd(ACT_REMAP, 8'd0, 24'h0, 8'd1), 1'b1);
        issue(make_cmd(ACT_REMAP, 8'd0, 24'h0, TRANSPARENT_PIXEL), 1'b0);
        issue(make_cmd(ACT_REMAP, 8'd0, 24'h0, BACKGROUND_PIXEL), 1'b0);

        foreach (counts[ph])
        begin
            set_count(counts[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                calm = (ph == 7) || ((i / 30) % 3 == 2);
                if (ph == 2 && i == 50)
                    drain();
                issue(random_cmd(ph == 0 && i < 40), !calm);
            end
        end

        drain();
        repeat (PAL_N + 8) @(posedge clk);
        if (sb.fail_count == 0 && sb.owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
